### hw/rtl/fault_edge_history_logger_defines.svh
// assertion macros for the fault edge history logger
// define ASSERT_OFF to compile them out; no other dependencies
`ifndef FAULT_EDGE_HISTORY_LOGGER_DEFINES_SVH
`define FAULT_EDGE_HISTORY_LOGGER_DEFINES_SVH

`ifndef ASSERT_OFF
`define FEHL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fehl assertion failed");
`define FEHL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fehl assertion failed");
`else
`define FEHL_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define FEHL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### hw/rtl/fehl_pkg.sv
// types, function codes and helpers of the fault edge history logger
// no dependencies
package fehl_pkg;

   localparam int GROUP_BITS = 16;
   localparam int REC_W      = 27;

   localparam logic [3:0] MONTH_MAX  = 4'd12;
   localparam logic [7:0] DAY_MAX    = 8'd31;
   localparam logic [7:0] HOUR_MAX   = 8'd23;
   localparam logic [7:0] MINUTE_MAX = 8'd59;

   typedef enum logic [1:0] {
      FUNC_UPDATE = 2'd0,
      FUNC_READ   = 2'd1,
      FUNC_CLEAR  = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   typedef struct packed {
      logic [1:0]  func;
      logic [1:0]  group_index;
      logic [15:0] fault_bits;
      logic [3:0]  now_month;
      logic [7:0]  now_day;
      logic [7:0]  now_hour;
      logic [7:0]  now_minute;
      logic [6:0]  read_age;
   } req_type;

   typedef struct packed {
      logic        entry_valid;
      logic [3:0]  entry_month;
      logic [4:0]  entry_day;
      logic [4:0]  entry_hour;
      logic [5:0]  entry_minute;
      logic [6:0]  entry_code;
      logic [4:0]  logged_now;
      logic [7:0]  record_count;
   } rsp_type;

   // one history record, month in the top bits
   typedef struct packed {
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [6:0] code;
   } record_type;

   // index of the lowest set bit, zero when none is set
   function automatic logic [3:0] lowest_set(input logic [15:0] bits);
      logic [3:0] idx;
      idx = 4'd0;
      for (int i = GROUP_BITS - 1; i >= 0; i--) begin
         if (bits[i]) begin
            idx = 4'(i);
         end
      end
      return idx;
   endfunction

   function automatic record_type make_stamp(input req_type req);
      record_type rec;
      rec.month  = (req.now_month > MONTH_MAX) ? MONTH_MAX : req.now_month;
      rec.day    = (req.now_day > DAY_MAX) ? DAY_MAX[4:0] : req.now_day[4:0];
      rec.hour   = (req.now_hour > HOUR_MAX) ? HOUR_MAX[4:0] : req.now_hour[4:0];
      rec.minute = (req.now_minute > MINUTE_MAX) ? MINUTE_MAX[5:0] : req.now_minute[5:0];
      rec.code   = 7'd0;
      return rec;
   endfunction

endpackage

### hw/rtl/fehl_hist_ram.sv
// history record memory: one write port, one registered read port
// depends on fehl_pkg for the record type
module fehl_hist_ram #(
   parameter int DEPTH  = 128,
   parameter int ADDR_W = 7
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [ADDR_W-1:0]   wr_addr,
   input  fehl_pkg::record_type wr_data,
   input  logic                rd_en,
   input  logic [ADDR_W-1:0]   rd_addr,
   output fehl_pkg::record_type rd_data
);
   import fehl_pkg::*;

   record_type mem [DEPTH];
   record_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/fault_edge_history_logger.sv
// top level of the fault edge history logger
// depends on fehl_pkg, fehl_hist_ram and fault_edge_history_logger_defines.svh
`include "fault_edge_history_logger_defines.svh"

// Keeps the last fault word of four 16-bit groups and logs every 0-to-1 edge,
// lowest bit first, as a timestamped record in a newest-first history of
// HISTORY_DEPTH records held in a single-port-write memory. One item is worked
// at a time and each gives one result beat. An update writes one record into
// the history memory per rising bit; a read waits for the memory's registered
// read; clear and the unused code go straight to the reply. A finished result
// waits in the output register while the next beat is accepted; an item only
// stalls in its reply state while the previous result is still waiting there.
// No clearing pass is needed after reset.
module fault_edge_history_logger #(
   parameter int HISTORY_DEPTH = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  fehl_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output fehl_pkg::rsp_type rsp_data
);
   import fehl_pkg::*;

   localparam int SLOT_W = $clog2(HISTORY_DEPTH);
   localparam int HELD_W = $clog2(HISTORY_DEPTH + 1);
   localparam int CMP_W  = (HELD_W > 7) ? HELD_W : 7;
   localparam int SUB_W  = CMP_W + 1;
   localparam logic [HELD_W-1:0] HELD_MAX = HELD_W'(HISTORY_DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PUSH,
      ST_READ,
      ST_REPLY
   } state_type;

   state_type          state_ff;
   logic [15:0]        prev_ff [4];
   logic [SLOT_W-1:0]  newest_ff;
   logic [HELD_W-1:0]  held_ff;
   logic [15:0]        rising_ff;
   logic [1:0]         group_ff;
   record_type         stamp_ff;
   logic [4:0]         logged_ff;
   logic               hit_ff;
   rsp_type            pend_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_data_ff;

   logic               accept;
   logic               out_free;
   logic [SUB_W-1:0]   age_x;
   logic [SUB_W-1:0]   newest_x;
   logic [SUB_W-1:0]   slot_x;
   logic               hit_in;
   logic [SLOT_W-1:0]  newest_in;
   logic [HELD_W-1:0]  held_inc;
   logic [3:0]         bit_idx;
   record_type         wr_rec;
   logic               wr_en;
   logic               rd_en;
   record_type         rd_rec;
   rsp_type            pend_start;

   assign accept   = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);

   // age to slot, modulo the depth
   assign age_x    = SUB_W'(req_data.read_age);
   assign newest_x = SUB_W'(newest_ff);
   assign hit_in   = age_x < SUB_W'(held_ff);
   assign slot_x   = (newest_x >= age_x) ? (newest_x - age_x)
                                         : (newest_x + SUB_W'(HISTORY_DEPTH) - age_x);

   assign newest_in = (newest_ff == SLOT_W'(HISTORY_DEPTH - 1)) ? '0
                                                                : newest_ff + 1'b1;
   assign held_inc  = (held_ff == HELD_MAX) ? held_ff : held_ff + 1'b1;
   assign bit_idx   = lowest_set(rising_ff);

   always_comb begin
      wr_rec      = stamp_ff;
      wr_rec.code = {group_ff, bit_idx} + 7'd1;
   end

   // result fields as they stand when an item is taken
   always_comb begin
      pend_start = '0;
      if (req_data.func != FUNC_CLEAR) begin
         pend_start.record_count = 8'(held_ff);
      end
   end

   assign wr_en = (state_ff == ST_PUSH) && (rising_ff != 16'd0);
   // history is only read while no push is in flight, so no forwarding
   assign rd_en = accept && (req_data.func == FUNC_READ) && hit_in;

   fehl_hist_ram #(
      .DEPTH (HISTORY_DEPTH),
      .ADDR_W(SLOT_W)
   ) u_hist_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(newest_in),
      .wr_data(wr_rec),
      .rd_en  (rd_en),
      .rd_addr(slot_x[SLOT_W-1:0]),
      .rd_data(rd_rec)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         newest_ff    <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int g = 0; g < 4; g++) begin
            prev_ff[g] <= 16'd0;
         end
      end else begin
         if ((state_ff == ST_REPLY) && out_free) begin
            rsp_valid_ff <= 1'b1;
            rsp_data_ff  <= pend_ff;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  pend_ff <= pend_start;
                  case (req_data.func)
                     FUNC_UPDATE: begin
                        rising_ff <= req_data.fault_bits & ~prev_ff[req_data.group_index];
                        prev_ff[req_data.group_index] <= req_data.fault_bits;
                        group_ff  <= req_data.group_index;
                        stamp_ff  <= make_stamp(req_data);
                        logged_ff <= 5'd0;
                        state_ff  <= ST_PUSH;
                     end
                     FUNC_READ: begin
                        hit_ff   <= hit_in;
                        state_ff <= ST_READ;
                     end
                     FUNC_CLEAR: begin
                        held_ff   <= '0;
                        newest_ff <= '0;
                        state_ff  <= ST_REPLY;
                     end
                     default: begin
                        state_ff <= ST_REPLY;
                     end
                  endcase
               end
            end
            ST_PUSH: begin
               if (rising_ff != 16'd0) begin
                  newest_ff <= newest_in;
                  held_ff   <= held_inc;
                  rising_ff[bit_idx] <= 1'b0;
                  logged_ff <= logged_ff + 5'd1;
               end else begin
                  pend_ff.logged_now   <= logged_ff;
                  pend_ff.record_count <= 8'(held_ff);
                  state_ff             <= ST_REPLY;
               end
            end
            ST_READ: begin
               if (hit_ff) begin
                  pend_ff.entry_valid  <= 1'b1;
                  pend_ff.entry_month  <= rd_rec.month;
                  pend_ff.entry_day    <= rd_rec.day;
                  pend_ff.entry_hour   <= rd_rec.hour;
                  pend_ff.entry_minute <= rd_rec.minute;
                  pend_ff.entry_code   <= rd_rec.code;
               end
               state_ff <= ST_REPLY;
            end
            ST_REPLY: begin
               if (out_free) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `FEHL_ASSERT_IMPLY(a_held_bound, clock, reset, 1'b1, held_ff <= HELD_MAX)
   `FEHL_ASSERT_NEXT(a_one_item, clock, reset, accept, !req_ready)
   `FEHL_ASSERT_NEXT(a_push_count, clock, reset, wr_en, held_ff == $past(held_inc))
   `FEHL_ASSERT_IMPLY(a_no_read_in_push, clock, reset, wr_en, !rd_en)

endmodule

### dv/fault_edge_history_logger_tb.sv
// testbench for fault_edge_history_logger: directed and random fault words, reads and clears,
// with every result predicted by a scoreboard that models the edge history
// depends on fehl_pkg and the fault_edge_history_logger rtl
`timescale 1ns / 1ps

import fehl_pkg::*;

class history_scoreboard;
   int depth;
   logic [15:0] prev_faults [4];
   record_type history [];
   int newest_slot;
   int held;
   rsp_type expected_rsps [$];
   int errors;
   int updates, records_pushed, records_dropped, read_hits, read_misses, clears, peak_held;

   function new(int history_depth);
      depth = history_depth;
      history = new[history_depth];
      foreach (prev_faults[g]) prev_faults[g] = '0;
      newest_slot = 0;
      held = 0;
      errors = 0;
      updates = 0;
      records_pushed = 0;
      records_dropped = 0;
      read_hits = 0;
      read_misses = 0;
      clears = 0;
      peak_held = 0;
   endfunction

   // works out the result of one accepted request and updates the history copy
   function void note_request(req_type item);
      rsp_type want;
      record_type stamp;
      logic [15:0] rising;
      int slot;
      want = '0;
      case (func_type'(item.func))
         FUNC_UPDATE: begin
            updates++;
            rising = item.fault_bits & ~prev_faults[item.group_index];
            stamp.month  = (item.now_month > MONTH_MAX) ? MONTH_MAX : item.now_month;
            stamp.day    = (item.now_day > DAY_MAX) ? 5'(DAY_MAX) : item.now_day[4:0];
            stamp.hour   = (item.now_hour > HOUR_MAX) ? 5'(HOUR_MAX) : item.now_hour[4:0];
            stamp.minute = (item.now_minute > MINUTE_MAX) ? 6'(MINUTE_MAX)
                                                          : item.now_minute[5:0];
            for (int b = 0; b < 16; b++) begin
               if (rising[b]) begin
                  stamp.code = 7'(item.group_index * 16 + b + 1);
                  newest_slot = (newest_slot + 1) % depth;
                  history[newest_slot] = stamp;
                  if (held < depth) held++;
                  else records_dropped++;
                  want.logged_now = want.logged_now + 5'd1;
                  records_pushed++;
               end
            end
            prev_faults[item.group_index] = item.fault_bits;
         end
         FUNC_READ: begin
            if (int'(item.read_age) < held) begin
               slot = (newest_slot + depth - int'(item.read_age)) % depth;
               want.entry_valid  = 1'b1;
               want.entry_month  = history[slot].month;
               want.entry_day    = history[slot].day;
               want.entry_hour   = history[slot].hour;
               want.entry_minute = history[slot].minute;
               want.entry_code   = history[slot].code;
               read_hits++;
            end else begin
               read_misses++;
            end
         end
         FUNC_CLEAR: begin
            held = 0;
            newest_slot = 0;
            clears++;
         end
         default: ;
      endcase
      if (held > peak_held) peak_held = held;
      want.record_count = 8'(held);
      expected_rsps.push_back(want);
   endfunction

   function void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         errors++;
      end
   endfunction

   function void check_rsp(rsp_type got);
      rsp_type want;
      if (expected_rsps.size() == 0) begin
         $error("result beat with nothing expected: %h", got);
         errors++;
         return;
      end
      want = expected_rsps.pop_front();
      check_field("entry_valid", 8'(want.entry_valid), 8'(got.entry_valid));
      check_field("entry_month", 8'(want.entry_month), 8'(got.entry_month));
      check_field("entry_day", 8'(want.entry_day), 8'(got.entry_day));
      check_field("entry_hour", 8'(want.entry_hour), 8'(got.entry_hour));
      check_field("entry_minute", 8'(want.entry_minute), 8'(got.entry_minute));
      check_field("entry_code", 8'(want.entry_code), 8'(got.entry_code));
      check_field("logged_now", 8'(want.logged_now), 8'(got.logged_now));
      check_field("record_count", want.record_count, got.record_count);
   endfunction
endclass

module fault_edge_history_logger_tb;

   localparam int DEPTH        = 128;
   localparam int RANDOM_ITEMS = 1300;
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_AT_ITEM = 400;
   localparam int DRAIN_CYCLES = 40;
   localparam int CYCLE_LIMIT  = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   history_scoreboard sb;
   logic hold_wanted = 1'b0;
   logic hold_done = 1'b0;
   int   rx_cycle = 0;

   fault_edge_history_logger #(
      .HISTORY_DEPTH(DEPTH)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic req_type make_req(func_type f, logic [1:0] group, logic [15:0] bits,
                                        logic [3:0] mon, logic [7:0] dy, logic [7:0] hr,
                                        logic [7:0] mi, logic [6:0] age);
      req_type item;
      item.func        = f;
      item.group_index = group;
      item.fault_bits  = bits;
      item.now_month   = mon;
      item.now_day     = dy;
      item.now_hour    = hr;
      item.now_minute  = mi;
      item.read_age    = age;
      return item;
   endfunction

   task automatic send_req(input req_type item);
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_request(item);
   endtask

   task automatic idle_cycles(input int n);
      @(negedge clock);
      req_valid <= 1'b0;
      repeat (n - 1) @(negedge clock);
   endtask

   function automatic req_type random_req();
      req_type item;
      int pick;
      logic [1:0] g;
      logic [15:0] bits;
      logic [6:0] age;
      pick = $urandom_range(99);
      g = 2'($urandom_range(3));
      if (pick < 58) begin
         case ($urandom_range(3))
            0: bits = 16'($urandom());
            1: bits = sb.prev_faults[g] ^ (16'($urandom()) & 16'($urandom()) & 16'($urandom()));
            2: bits = (sb.prev_faults[g] == 16'h0000) ? 16'hffff : 16'h0000;
            default: bits = sb.prev_faults[g];
         endcase
         if ($urandom_range(1))
            item = make_req(FUNC_UPDATE, g, bits, 4'($urandom_range(15)),
                            8'($urandom_range(255)), 8'($urandom_range(255)),
                            8'($urandom_range(255)), 7'($urandom_range(127)));
         else
            item = make_req(FUNC_UPDATE, g, bits, 4'($urandom_range(12)),
                            8'($urandom_range(31)), 8'($urandom_range(23)),
                            8'($urandom_range(59)), 7'($urandom_range(127)));
      end else if (pick < 95) begin
         if (sb.held > 0 && $urandom_range(3) != 0) age = 7'($urandom_range(sb.held - 1));
         else age = 7'($urandom_range(127));
         item = make_req(FUNC_READ, g, 16'($urandom()), 4'($urandom_range(15)),
                         8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), age);
      end else if (pick < 97) begin
         item = make_req(FUNC_CLEAR, g, 16'($urandom()), 4'($urandom_range(15)),
                         8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), 7'($urandom_range(127)));
      end else begin
         item = make_req(FUNC_NONE, g, 16'($urandom()), 4'($urandom_range(15)),
                         8'($urandom_range(255)), 8'($urandom_range(255)),
                         8'($urandom_range(255)), 7'($urandom_range(127)));
      end
      return item;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) sb.check_rsp(rsp_data);
   end

   // result side: one long hold-off on request, otherwise rotating stall patterns
   initial begin
      forever begin
         @(negedge clock);
         rx_cycle++;
         if (hold_wanted && !hold_done) begin
            rsp_ready <= 1'b0;
            hold_done = 1'b1;
            repeat (HOLD_CYCLES - 1) @(negedge clock);
         end else begin
            case ((rx_cycle / 150) % 4)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= ($urandom_range(99) < 70);
               2: rsp_ready <= (rx_cycle % 5 != 0);
               default: rsp_ready <= ($urandom_range(3) == 0);
            endcase
         end
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("tb: failure");
      $finish;
   end

   initial begin
      int sent;
      int burst;
      int no_gap_left;
      req_type item;
      sb = new(DEPTH);
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // empty history, unused code, then edges with zero, maximal and boundary times
      send_req(make_req(FUNC_READ, 2'd0, 16'h0000, 4'd0, 8'd0, 8'd0, 8'd0, 7'd0));
      send_req(make_req(FUNC_NONE, 2'd3, 16'hffff, 4'd15, 8'd255, 8'd255, 8'd255, 7'd127));
      send_req(make_req(FUNC_UPDATE, 2'd0, 16'h0001, 4'd0, 8'd0, 8'd0, 8'd0, 7'd0));
      send_req(make_req(FUNC_UPDATE, 2'd0, 16'hffff, 4'd15, 8'd255, 8'd255, 8'd255, 7'd127));
      send_req(make_req(FUNC_UPDATE, 2'd0, 16'hffff, 4'd3, 8'd4, 8'd5, 8'd6, 7'd0));
      send_req(make_req(FUNC_UPDATE, 2'd0, 16'h0000, 4'd3, 8'd4, 8'd5, 8'd6, 7'd0));
      send_req(make_req(FUNC_UPDATE, 2'd3, 16'hffff, 4'd12, 8'd31, 8'd23, 8'd59, 7'd0));
      send_req(make_req(FUNC_UPDATE, 2'd1, 16'haaaa, 4'd13, 8'd32, 8'd24, 8'd60, 7'd0));
      send_req(make_req(FUNC_UPDATE, 2'd2, 16'h5555, 4'd11, 8'd30, 8'd22, 8'd58, 7'd0));
      send_req(make_req(FUNC_READ, 2'd0, 16'h0000, 4'd0, 8'd0, 8'd0, 8'd0, 7'd0));
      send_req(make_req(FUNC_READ, 2'd0, 16'h0000, 4'd0, 8'd0, 8'd0, 8'd0, 7'd1));
      send_req(make_req(FUNC_READ, 2'd0, 16'h0000, 4'd0, 8'd0, 8'd0, 8'd0,
                        7'(sb.held - 1)));
      send_req(make_req(FUNC_READ, 2'd0, 16'h0000, 4'd0, 8'd0, 8'd0, 8'd0, 7'(sb.held)));
      send_req(make_req(FUNC_READ, 2'd0, 16'h0000, 4'd0, 8'd0, 8'd0, 8'd0, 7'd127));
      // clear keeps the stored fault words
      send_req(make_req(FUNC_CLEAR, 2'd0, 16'h0000, 4'd0, 8'd0, 8'd0, 8'd0, 7'd0));
      send_req(make_req(FUNC_READ, 2'd0, 16'h0000, 4'd0, 8'd0, 8'd0, 8'd0, 7'd0));
      send_req(make_req(FUNC_UPDATE, 2'd3, 16'hffff, 4'd1, 8'd2, 8'd3, 8'd4, 7'd0));
      send_req(make_req(FUNC_UPDATE, 2'd3, 16'h0000, 4'd1, 8'd2, 8'd3, 8'd4, 7'd0));
      send_req(make_req(FUNC_UPDATE, 2'd3, 16'h8000, 4'd7, 8'd8, 8'd9, 8'd10, 7'd0));
      send_req(make_req(FUNC_READ, 2'd0, 16'h0000, 4'd0, 8'd0, 8'd0, 8'd0, 7'd0));
      send_req(make_req(FUNC_NONE, 2'd0, 16'h0000, 4'd0, 8'd0, 8'd0, 8'd0, 7'd0));

      sent = 0;
      no_gap_left = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 20);
         repeat (burst) begin
            item = random_req();
            send_req(item);
            if (func_type'(item.func) != FUNC_NONE) sent++;
            if (sent == HOLD_AT_ITEM && !hold_wanted) begin
               hold_wanted = 1'b1;
               no_gap_left = 40;
            end
         end
         // keep offering beats back to back while the result side is held off
         if (no_gap_left > 0) no_gap_left -= burst;
         else if ($urandom_range(9) < 7) idle_cycles($urandom_range(1, 8));
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (sb.expected_rsps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d updates pushing %0d records (%0d dropped when full), peak %0d held",
               sb.updates, sb.records_pushed, sb.records_dropped, sb.peak_held);
      $display("reads: %0d found a record, %0d past the history; %0d clears",
               sb.read_hits, sb.read_misses, sb.clears);
      if (sb.errors == 0 && sb.expected_rsps.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

### fault_edge_history_logger.f
+incdir+hw/rtl
hw/rtl/fehl_pkg.sv
hw/rtl/fehl_hist_ram.sv
hw/rtl/fault_edge_history_logger.sv
dv/fault_edge_history_logger_tb.sv
